[hw/rtl/tspg_pkg.sv]
// package: types, codes and constants of the three-axis step pulse generator
`default_nettype none
package tspg_pkg;

	localparam int TimerW   = 16;
	localparam int PeriodW  = 16;
	localparam int CmpW     = (TimerW > PeriodW) ? TimerW : PeriodW;
	localparam int StepsW   = 32;
	localparam int DurW     = 17;
	localparam int StepInW  = 20;
	localparam int CmdW     = 3;
	localparam int ReplyW   = 2;
	localparam int ApbAddrW = 3;
	localparam int ApbDataW = 32;

	localparam logic [PeriodW-1:0] HomePeriodReset = PeriodW'(1500);
	localparam logic [PeriodW-1:0] PeriodReset     = '1;

	typedef enum logic [CmdW-1:0] {
		CmdHome  = 3'd0,
		CmdMoveX = 3'd1,
		CmdMoveZ = 3'd2,
		CmdMoveE = 3'd3,
		CmdStart = 3'd4,
		CmdAlive = 3'd5
	} cmd_e;

	localparam logic [ReplyW-1:0] ReplyNone  = 2'd0;
	localparam logic [ReplyW-1:0] ReplyEcho  = 2'd1;
	localparam logic [ReplyW-1:0] ReplyAlive = 2'd2;

	localparam logic RegHomePeriod = 1'b0;

	typedef struct packed {
		logic                tick;
		logic                ld;
		logic                ld_steps;
		logic                clear;
		logic                homing;
		logic                armed;
		logic                dir;
		logic [PeriodW-1:0]  period;
		logic [PeriodW-1:0]  half;
		logic [StepInW-1:0]  steps;
	} axis_ctl_t;

	typedef struct packed {
		logic step;
		logic dir;
	} axis_pin_t;

	typedef struct packed {
		logic              x_step_pin;
		logic              z_step_pin;
		logic              e_step_pin;
		logic              x_dir_pin;
		logic              z_dir_pin;
		logic              e_dir_pin;
		logic [ReplyW-1:0] reply;
		logic              homing_done;
		logic              move_done;
	} res_t;

endpackage
`default_nettype wire

[hw/rtl/tspg_if.sv]
// interfaces: command/tick item channel and result item channel
`default_nettype none
interface tspg_in_if;
	logic                           valid;
	logic                           ready;
	logic                           kind;
	logic [tspg_pkg::CmdW-1:0]      command;
	logic                           direction;
	logic [tspg_pkg::DurW-1:0]      duration;
	logic [tspg_pkg::StepInW-1:0]   steps;
	logic                           x_limit;
	logic                           z_limit;

	modport source (output valid, kind, command, direction, duration, steps, x_limit, z_limit,
		input ready);
	modport sink (input valid, kind, command, direction, duration, steps, x_limit, z_limit,
		output ready);
endinterface

interface tspg_out_if;
	logic                           valid;
	logic                           ready;
	logic                           x_step_pin;
	logic                           z_step_pin;
	logic                           e_step_pin;
	logic                           x_dir_pin;
	logic                           z_dir_pin;
	logic                           e_dir_pin;
	logic [tspg_pkg::ReplyW-1:0]    reply;
	logic                           homing_done;
	logic                           move_done;

	modport source (output valid, x_step_pin, z_step_pin, e_step_pin, x_dir_pin, z_dir_pin,
		e_dir_pin, reply, homing_done, move_done, input ready);
	modport sink (input valid, x_step_pin, z_step_pin, e_step_pin, x_dir_pin, z_dir_pin,
		e_dir_pin, reply, homing_done, move_done, output ready);
endinterface
`default_nettype wire

[hw/rtl/tspg_axis.sv]
// one axis: timer, period, half period, step count and pin levels
`default_nettype none
module tspg_axis (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire tspg_pkg::axis_ctl_t    ctl,
	output tspg_pkg::axis_pin_t         pin_nx,
	output logic                        cnt_zero
);

	logic [tspg_pkg::TimerW-1:0]  timer_q, timer_d, timer_nx;
	logic [tspg_pkg::TimerW-1:0]  period_q, period_d;
	logic [tspg_pkg::PeriodW-1:0] half_q, half_d;
	logic [tspg_pkg::StepsW-1:0]  cnt_q, cnt_d, cnt_eff;
	logic                         lvl_q, lvl_d;
	logic                         dir_q, dir_d;
	logic                         pos, act;
	logic [tspg_pkg::CmpW-1:0]    tw, hw;

	assign timer_nx = (timer_q >= period_q) ? '0 : timer_q + 1'b1;
	assign cnt_eff  = ctl.clear ? '0 : cnt_q;
	assign cnt_zero = (cnt_eff == '0);
	assign pos      = (cnt_eff != '0) && !cnt_eff[tspg_pkg::StepsW-1];
	assign act      = ctl.homing || (ctl.armed && pos);

	always_comb begin
		timer_d  = ctl.tick ? timer_nx : timer_q;
		period_d = period_q;
		half_d   = half_q;
		cnt_d    = cnt_eff;
		lvl_d    = lvl_q;
		dir_d    = dir_q;
		tw       = tspg_pkg::CmpW'(timer_d);
		hw       = tspg_pkg::CmpW'(half_q);
		if (ctl.tick && act) begin
			if (tw > hw && !lvl_q) begin
				lvl_d = 1'b1;
				cnt_d = cnt_eff - 1'b1;
			end else if (tw < hw && lvl_q) begin
				lvl_d = 1'b0;
			end
		end
		if (ctl.ld) begin
			period_d = tspg_pkg::TimerW'(ctl.period);
			half_d   = ctl.half;
			dir_d    = ctl.dir;
		end
		if (ctl.ld_steps) begin
			cnt_d = tspg_pkg::StepsW'(ctl.steps);
		end
	end

	assign pin_nx = '{step: lvl_d, dir: dir_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q  <= '0;
			period_q <= tspg_pkg::TimerW'(tspg_pkg::PeriodReset);
			half_q   <= '0;
			cnt_q    <= '0;
			lvl_q    <= 1'b0;
			dir_q    <= 1'b0;
		end else if (en) begin
			timer_q  <= timer_d;
			period_q <= period_d;
			half_q   <= half_d;
			cnt_q    <= cnt_d;
			lvl_q    <= lvl_d;
			dir_q    <= dir_d;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/three_axis_step_pulse_generator.sv]
// top level: three-axis step/direction generator with command decode and result buffer
//
// Takes one item (timer tick or decoded command) per clock when ready and gives exactly
// one result item per accepted item. All axis work is a single pass of compares and one
// 32-bit decrement between the input handshake and the result register, so the rate is
// one item per cycle when ready. Results go through a two-entry output buffer: input
// ready only drops when both entries hold results that the sink has not taken. The user
// must write the home period register over APB only while the block is idle (unenforced).
`default_nettype none
module three_axis_step_pulse_generator (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	tspg_in_if.sink                               cmd_in,
	tspg_out_if.source                            res_out,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [tspg_pkg::ApbAddrW-1:0]    paddr,
	input  wire logic [tspg_pkg::ApbDataW-1:0]    pwdata,
	output logic [tspg_pkg::ApbDataW-1:0]         prdata,
	output logic                                  pready
);

	logic [tspg_pkg::PeriodW-1:0] home_period_q;
	logic [1:0]                   hf_q, hf_after, hf_d;
	logic                         armed_q, armed_after, armed_d;
	logic                         accept, tick, homing_act, home_end, mdone;
	logic                         c_home, c_mvx, c_mvz, c_mve, c_start;
	logic [tspg_pkg::ReplyW-1:0]  reply;
	logic                         x_zero, z_zero, e_zero;
	tspg_pkg::axis_ctl_t          ctl_x, ctl_z, ctl_e;
	tspg_pkg::axis_pin_t          pin_x, pin_z, pin_e;
	tspg_pkg::res_t               res_new, out_q, skid_q;
	logic                         out_valid_q, skid_valid_q, pop;

	// config port
	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		if (paddr[tspg_pkg::ApbAddrW-1] == tspg_pkg::RegHomePeriod) begin
			prdata = tspg_pkg::ApbDataW'(home_period_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			home_period_q <= tspg_pkg::HomePeriodReset;
		end else if (psel && penable && pwrite && pready
			&& paddr[tspg_pkg::ApbAddrW-1] == tspg_pkg::RegHomePeriod) begin
			home_period_q <= pwdata[tspg_pkg::PeriodW-1:0];
		end
	end

	// command decode
	assign accept = cmd_in.valid && cmd_in.ready;
	assign tick   = !cmd_in.kind;

	always_comb begin
		c_home  = 1'b0;
		c_mvx   = 1'b0;
		c_mvz   = 1'b0;
		c_mve   = 1'b0;
		c_start = 1'b0;
		reply   = tspg_pkg::ReplyNone;
		if (cmd_in.kind) begin
			unique case (tspg_pkg::cmd_e'(cmd_in.command))
				tspg_pkg::CmdHome: begin
					c_home = 1'b1;
				end
				tspg_pkg::CmdMoveX: begin
					c_mvx = 1'b1;
					reply = tspg_pkg::ReplyEcho;
				end
				tspg_pkg::CmdMoveZ: begin
					c_mvz = 1'b1;
					reply = tspg_pkg::ReplyEcho;
				end
				tspg_pkg::CmdMoveE: begin
					c_mve = 1'b1;
					reply = tspg_pkg::ReplyEcho;
				end
				tspg_pkg::CmdStart: begin
					c_start = 1'b1;
					reply   = tspg_pkg::ReplyEcho;
				end
				tspg_pkg::CmdAlive: begin
					reply = tspg_pkg::ReplyAlive;
				end
				default: begin
					reply = tspg_pkg::ReplyNone;
				end
			endcase
		end
	end

	// homing and move completion on ticks
	assign homing_act  = |hf_q;
	assign hf_after    = homing_act ? (hf_q & ~{cmd_in.z_limit, cmd_in.x_limit}) : hf_q;
	assign home_end    = tick && homing_act && (hf_after == 2'b00);
	assign mdone       = tick && armed_q && x_zero && z_zero;
	assign armed_after = armed_q && !mdone;

	always_comb begin
		hf_d    = hf_q;
		armed_d = armed_q;
		if (tick) begin
			hf_d    = hf_after;
			armed_d = armed_after;
		end else if (c_home) begin
			hf_d = 2'b11;
		end else if (c_start) begin
			armed_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hf_q    <= 2'b00;
			armed_q <= 1'b0;
		end else if (accept) begin
			hf_q    <= hf_d;
			armed_q <= armed_d;
		end
	end

	// axis controls
	always_comb begin
		ctl_x = '{
			tick:     tick,
			ld:       c_home || c_mvx,
			ld_steps: c_mvx,
			clear:    home_end,
			homing:   hf_after[0],
			armed:    armed_after,
			dir:      c_home ? 1'b0 : cmd_in.direction,
			period:   c_home ? home_period_q : cmd_in.duration[tspg_pkg::PeriodW-1:0],
			half:     c_home ? (home_period_q >> 1) : cmd_in.duration[tspg_pkg::DurW-1:1],
			steps:    cmd_in.steps
		};
		ctl_z = ctl_x;
		ctl_z.ld       = c_home || c_mvz;
		ctl_z.ld_steps = c_mvz;
		ctl_z.homing   = hf_after[1];
		ctl_e = ctl_x;
		ctl_e.ld       = c_mve;
		ctl_e.ld_steps = c_mve;
		ctl_e.clear    = 1'b0;
		ctl_e.homing   = 1'b0;
		ctl_e.dir      = cmd_in.direction;
		ctl_e.period   = cmd_in.duration[tspg_pkg::PeriodW-1:0];
		ctl_e.half     = cmd_in.duration[tspg_pkg::DurW-1:1];
	end

	tspg_axis u_axis_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (accept),
		.ctl      (ctl_x),
		.pin_nx   (pin_x),
		.cnt_zero (x_zero)
	);

	tspg_axis u_axis_z (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (accept),
		.ctl      (ctl_z),
		.pin_nx   (pin_z),
		.cnt_zero (z_zero)
	);

	tspg_axis u_axis_e (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (accept),
		.ctl      (ctl_e),
		.pin_nx   (pin_e),
		.cnt_zero (e_zero)
	);

	// result item
	always_comb begin
		res_new = '{
			x_step_pin:  pin_x.step,
			z_step_pin:  pin_z.step,
			e_step_pin:  pin_e.step,
			x_dir_pin:   pin_x.dir,
			z_dir_pin:   pin_z.dir,
			e_dir_pin:   pin_e.dir,
			reply:       reply,
			homing_done: home_end,
			move_done:   mdone && !e_zero ? mdone : mdone
		};
	end

	// two-entry output buffer
	assign cmd_in.ready = !skid_valid_q;
	assign pop          = out_valid_q && res_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			if (!out_valid_q) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= res_new;
			end
		end else if (accept) begin
			if (!out_valid_q) begin
				out_q <= res_new;
			end else begin
				skid_q <= res_new;
			end
		end
	end

	assign res_out.valid       = out_valid_q;
	assign res_out.x_step_pin  = out_q.x_step_pin;
	assign res_out.z_step_pin  = out_q.z_step_pin;
	assign res_out.e_step_pin  = out_q.e_step_pin;
	assign res_out.x_dir_pin   = out_q.x_dir_pin;
	assign res_out.z_dir_pin   = out_q.z_dir_pin;
	assign res_out.e_dir_pin   = out_q.e_dir_pin;
	assign res_out.reply       = out_q.reply;
	assign res_out.homing_done = out_q.homing_done;
	assign res_out.move_done   = out_q.move_done;

endmodule
`default_nettype wire

[hw/rtl/tspg_checker.sv]
// checker: port-level properties of the step pulse generator, bound to the top level
`default_nettype none
module tspg_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [tspg_pkg::ReplyW-1:0]   reply,
	input wire logic                          homing_done,
	input wire logic                          move_done,
	input wire logic                          x_step_pin
);

	// a held result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(reply) && $stable(homing_done)
			&& $stable(move_done) && $stable(x_step_pin))
		else $error("result item changed while stalled");

	// back-pressure only when a result is waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

	// an item with a reply code never flags homing or move completion
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (reply != tspg_pkg::ReplyNone) |-> !homing_done && !move_done)
		else $error("done flag on a command reply");

	// accepted item with free space shows up next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted item did not produce a result");

	// reply code three is never produced
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> reply != 2'd3)
		else $error("unused reply code");

endmodule

bind three_axis_step_pulse_generator tspg_checker u_tspg_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (cmd_in.valid),
	.in_ready    (cmd_in.ready),
	.out_valid   (res_out.valid),
	.out_ready   (res_out.ready),
	.reply       (res_out.reply),
	.homing_done (res_out.homing_done),
	.move_done   (res_out.move_done),
	.x_step_pin  (res_out.x_step_pin)
);
`default_nettype wire

[sim/testbench.sv]
`timescale 1ns / 1ps
// testbench: step pulse generator driven with ticks and commands, every result item checked
module testbench;

	localparam int AxisX   = 0;
	localparam int AxisZ   = 1;
	localparam int AxisE   = 2;
	localparam int NumAxes = 3;

	localparam logic KindTick = 1'b0;
	localparam logic KindCmd  = 1'b1;

	localparam logic [tspg_pkg::CmdW-1:0]     CmdUnknownLo   = 3'd6;
	localparam logic [tspg_pkg::CmdW-1:0]     CmdUnknownHi   = 3'd7;
	localparam logic [tspg_pkg::ApbAddrW-1:0] HomePeriodAddr =
		tspg_pkg::ApbAddrW'(4 * int'(tspg_pkg::RegHomePeriod));
	localparam logic [tspg_pkg::DurW-1:0]     DurMax         = '1;
	localparam logic [tspg_pkg::StepInW-1:0]  StepsMax       = '1;
	localparam logic [tspg_pkg::PeriodW-1:0]  HomePeriodMax  = '1;

	localparam int ItemTarget   = 1150;
	localparam int PhaseItems   = 160;
	localparam int SettleCycles = 4;
	localparam int LongHold     = 60;
	localparam int StallLimit   = 2000;

	typedef struct {
		logic                          kind;
		logic [tspg_pkg::CmdW-1:0]     command;
		logic                          direction;
		logic [tspg_pkg::DurW-1:0]     duration;
		logic [tspg_pkg::StepInW-1:0]  steps;
		logic                          x_limit;
		logic                          z_limit;
	} cmd_item_t;

	class pulse_tracker;
		tspg_pkg::res_t             expected_pins[$];
		bit [tspg_pkg::StepsW-1:0]  steps_left[NumAxes];
		bit [tspg_pkg::PeriodW-1:0] period[NumAxes];
		bit [tspg_pkg::PeriodW-1:0] half[NumAxes];
		bit [tspg_pkg::TimerW-1:0]  timer[NumAxes];
		bit                         step_lvl[NumAxes];
		bit                         dir_lvl[NumAxes];
		bit                         homing[2];
		bit                         armed;
		bit [tspg_pkg::PeriodW-1:0] home_period;
		int                         fails;
		int                         checked;
		int                         home_events;
		int                         move_events;

		function new();
			for (int a = 0; a < NumAxes; a++) begin
				steps_left[a] = '0;
				period[a]     = tspg_pkg::PeriodReset;
				half[a]       = '0;
				timer[a]      = '0;
				step_lvl[a]   = 1'b0;
				dir_lvl[a]    = 1'b0;
			end
			homing[AxisX] = 1'b0;
			homing[AxisZ] = 1'b0;
			armed         = 1'b0;
			home_period   = tspg_pkg::HomePeriodReset;
			fails         = 0;
			checked       = 0;
			home_events   = 0;
			move_events   = 0;
		endfunction

		function bit counting(int a);
			return steps_left[a] != '0 && !steps_left[a][tspg_pkg::StepsW-1];
		endfunction

		function void advance_pin(int a);
			if (timer[a] > half[a] && !step_lvl[a]) begin
				step_lvl[a]   = 1'b1;
				steps_left[a] = steps_left[a] - 1'b1;
			end else if (timer[a] < half[a] && step_lvl[a]) begin
				step_lvl[a] = 1'b0;
			end
		endfunction

		function void note_item(cmd_item_t it);
			tspg_pkg::res_t r;
			int             a;
			r = '0;
			if (it.kind == KindCmd) begin
				case (it.command)
					tspg_pkg::CmdHome: begin
						for (a = AxisX; a <= AxisZ; a++) begin
							dir_lvl[a] = 1'b0;
							homing[a]  = 1'b1;
							period[a]  = home_period;
							half[a]    = home_period >> 1;
						end
					end
					tspg_pkg::CmdMoveX, tspg_pkg::CmdMoveZ, tspg_pkg::CmdMoveE: begin
						a             = int'(it.command) - int'(tspg_pkg::CmdMoveX);
						steps_left[a] = tspg_pkg::StepsW'(it.steps);
						period[a]     = it.duration[tspg_pkg::PeriodW-1:0];
						half[a]       = it.duration[tspg_pkg::DurW-1:1];
						dir_lvl[a]    = it.direction;
						r.reply       = tspg_pkg::ReplyEcho;
					end
					tspg_pkg::CmdStart: begin
						armed   = 1'b1;
						r.reply = tspg_pkg::ReplyEcho;
					end
					tspg_pkg::CmdAlive: begin
						r.reply = tspg_pkg::ReplyAlive;
					end
					default: begin
					end
				endcase
			end else begin
				for (a = 0; a < NumAxes; a++)
					timer[a] = (timer[a] >= period[a]) ? '0 : timer[a] + 1'b1;
				if (homing[AxisX] || homing[AxisZ]) begin
					if (it.x_limit)
						homing[AxisX] = 1'b0;
					if (it.z_limit)
						homing[AxisZ] = 1'b0;
					if (!homing[AxisX] && !homing[AxisZ]) begin
						steps_left[AxisX] = '0;
						steps_left[AxisZ] = '0;
						r.homing_done     = 1'b1;
					end
				end
				if (armed && steps_left[AxisX] == '0 && steps_left[AxisZ] == '0) begin
					r.move_done = 1'b1;
					armed       = 1'b0;
				end
				if ((armed && counting(AxisX)) || homing[AxisX])
					advance_pin(AxisX);
				if ((armed && counting(AxisZ)) || homing[AxisZ])
					advance_pin(AxisZ);
				if (armed && counting(AxisE))
					advance_pin(AxisE);
			end
			r.x_step_pin = step_lvl[AxisX];
			r.z_step_pin = step_lvl[AxisZ];
			r.e_step_pin = step_lvl[AxisE];
			r.x_dir_pin  = dir_lvl[AxisX];
			r.z_dir_pin  = dir_lvl[AxisZ];
			r.e_dir_pin  = dir_lvl[AxisE];
			expected_pins.push_back(r);
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			fails++;
		endtask

		task compare_field(string name, int got, int want);
			if (got != want)
				report($sformatf("result %0d field %s: got %0d, expected %0d",
					checked, name, got, want));
		endtask

		task check_result(tspg_pkg::res_t got);
			tspg_pkg::res_t want;
			if (expected_pins.size() == 0) begin
				report("result item arrived with nothing expected");
				return;
			end
			want = expected_pins.pop_front();
			checked++;
			home_events += int'(want.homing_done);
			move_events += int'(want.move_done);
			compare_field("x_step_pin", int'(got.x_step_pin), int'(want.x_step_pin));
			compare_field("z_step_pin", int'(got.z_step_pin), int'(want.z_step_pin));
			compare_field("e_step_pin", int'(got.e_step_pin), int'(want.e_step_pin));
			compare_field("x_dir_pin", int'(got.x_dir_pin), int'(want.x_dir_pin));
			compare_field("z_dir_pin", int'(got.z_dir_pin), int'(want.z_dir_pin));
			compare_field("e_dir_pin", int'(got.e_dir_pin), int'(want.e_dir_pin));
			compare_field("reply", int'(got.reply), int'(want.reply));
			compare_field("homing_done", int'(got.homing_done), int'(want.homing_done));
			compare_field("move_done", int'(got.move_done), int'(want.move_done));
		endtask
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [tspg_pkg::ApbAddrW-1:0] paddr;
	logic [tspg_pkg::ApbDataW-1:0] pwdata;
	logic [tspg_pkg::ApbDataW-1:0] prdata;
	logic                          pready;

	tspg_in_if  cmd_in();
	tspg_out_if res_out();

	pulse_tracker tracker;
	int           sent_items;
	int           quiet_cycles;
	bit           no_idle;
	bit           hold_request;
	bit           holding;

	three_axis_step_pulse_generator dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_in  (cmd_in),
		.res_out (res_out),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 2);
		if (r < 97)
			return $urandom_range(3, 8);
		return $urandom_range(15, 40);
	endfunction

	function automatic logic [tspg_pkg::DurW-1:0] rand_duration();
		if ($urandom_range(0, 9) == 0)
			return tspg_pkg::DurW'($urandom);
		return tspg_pkg::DurW'($urandom_range(0, 12));
	endfunction

	function automatic logic [tspg_pkg::StepInW-1:0] rand_steps();
		if ($urandom_range(0, 9) == 0)
			return tspg_pkg::StepInW'($urandom);
		return tspg_pkg::StepInW'($urandom_range(0, 5));
	endfunction

	function automatic logic rare_limit();
		return $urandom_range(0, 99) < 8;
	endfunction

	function automatic logic rand_bit();
		return 1'($urandom_range(0, 1));
	endfunction

	task automatic offer_item(cmd_item_t it);
		int gap;
		cmd_in.valid     <= 1'b1;
		cmd_in.kind      <= it.kind;
		cmd_in.command   <= it.command;
		cmd_in.direction <= it.direction;
		cmd_in.duration  <= it.duration;
		cmd_in.steps     <= it.steps;
		cmd_in.x_limit   <= it.x_limit;
		cmd_in.z_limit   <= it.z_limit;
		@(posedge clk);
		while (!cmd_in.ready)
			@(posedge clk);
		tracker.note_item(it);
		sent_items++;
		gap = no_idle ? 0 : idle_span();
		if (gap > 0) begin
			cmd_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_tick(logic xl, logic zl);
		cmd_item_t it;
		it.kind      = KindTick;
		it.command   = tspg_pkg::CmdW'($urandom);
		it.direction = rand_bit();
		it.duration  = tspg_pkg::DurW'($urandom);
		it.steps     = tspg_pkg::StepInW'($urandom);
		it.x_limit   = xl;
		it.z_limit   = zl;
		offer_item(it);
	endtask

	task automatic send_cmd(logic [tspg_pkg::CmdW-1:0] code, logic dir,
		logic [tspg_pkg::DurW-1:0] dur, logic [tspg_pkg::StepInW-1:0] count);
		cmd_item_t it;
		it.kind      = KindCmd;
		it.command   = code;
		it.direction = dir;
		it.duration  = dur;
		it.steps     = count;
		it.x_limit   = rand_bit();
		it.z_limit   = rand_bit();
		offer_item(it);
	endtask

	task automatic await_quiet();
		cmd_in.valid <= 1'b0;
		while (tracker.expected_pins.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_home_period(logic [tspg_pkg::PeriodW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= HomePeriodAddr;
		pwdata  <= tspg_pkg::ApbDataW'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		tracker.home_period = value;
		@(posedge clk);
	endtask

	always @(posedge clk) begin : result_monitor
		tspg_pkg::res_t got;
		got = {res_out.x_step_pin, res_out.z_step_pin, res_out.e_step_pin,
			res_out.x_dir_pin, res_out.z_dir_pin, res_out.e_dir_pin,
			res_out.reply, res_out.homing_done, res_out.move_done};
		if (arst_n && res_out.valid && res_out.ready)
			tracker.check_result(got);
	end

	always @(posedge clk) begin
		if ((cmd_in.valid && cmd_in.ready) || (res_out.valid && res_out.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin : result_sink
		int span;
		bit level;
		level         = 1'b0;
		res_out.ready = 1'b0;
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				holding      = 1'b1;
				level        = 1'b0;
				span         = LongHold;
			end else begin
				holding = 1'b0;
				if (no_idle || !level) begin
					level = 1'b1;
					span  = $urandom_range(1, 24);
				end else begin
					level = 1'b0;
					span  = idle_span() + 1;
				end
			end
			res_out.ready <= level;
			repeat (span) @(posedge clk);
		end
	end

	initial begin : stimulus
		int                           phase;
		int                           phase_start;
		int                           pick;
		int                           a;
		logic [tspg_pkg::PeriodW-1:0] home_setting;
		tracker           = new();
		sent_items        = 0;
		quiet_cycles      = 0;
		no_idle           = 1'b0;
		hold_request      = 1'b0;
		holding           = 1'b0;
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		cmd_in.valid      = 1'b0;
		cmd_in.kind       = KindTick;
		cmd_in.command    = tspg_pkg::CmdHome;
		cmd_in.direction  = 1'b0;
		cmd_in.duration   = '0;
		cmd_in.steps      = '0;
		cmd_in.x_limit    = 1'b0;
		cmd_in.z_limit    = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: replies, unknown codes, extreme fields, homing ending on an armed move
		write_home_period(tspg_pkg::PeriodW'(1));
		send_cmd(tspg_pkg::CmdAlive, 1'b0, '0, '0);
		send_cmd(CmdUnknownLo, 1'b1, DurMax, StepsMax);
		send_cmd(CmdUnknownHi, 1'b1, DurMax, StepsMax);
		send_cmd(tspg_pkg::CmdStart, 1'b0, '0, '0);
		send_tick(1'b0, 1'b0);
		send_cmd(tspg_pkg::CmdMoveX, 1'b1, DurMax, StepsMax);
		send_cmd(tspg_pkg::CmdMoveZ, 1'b1, tspg_pkg::DurW'(3), tspg_pkg::StepInW'(2));
		send_cmd(tspg_pkg::CmdMoveE, 1'b1, tspg_pkg::DurW'(1), tspg_pkg::StepInW'(3));
		send_cmd(tspg_pkg::CmdStart, 1'b0, '0, '0);
		repeat (5) send_tick(1'b1, 1'b1);
		send_cmd(tspg_pkg::CmdHome, 1'b1, DurMax, StepsMax);
		repeat (3) send_tick(1'b0, 1'b0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		send_tick(1'b0, 1'b1);
		send_cmd(tspg_pkg::CmdMoveX, 1'b0, '0, tspg_pkg::StepInW'(1));
		send_cmd(tspg_pkg::CmdStart, 1'b0, '0, '0);
		repeat (2) send_tick(1'b0, 1'b0);
		await_quiet();

		phase = 0;
		while (sent_items < ItemTarget) begin
			case (phase % 6)
				0: home_setting = tspg_pkg::PeriodW'(2);
				1: home_setting = tspg_pkg::PeriodW'(1);
				2: home_setting = tspg_pkg::PeriodW'($urandom_range(3, 12));
				3: home_setting = HomePeriodMax;
				4: home_setting = tspg_pkg::HomePeriodReset;
				default: home_setting = tspg_pkg::PeriodW'($urandom_range(1, 6));
			endcase
			write_home_period(home_setting);
			no_idle = (phase % 5 == 4);

			// result side stalls long enough for the output buffer to fill
			if (phase == 1) begin
				hold_request = 1'b1;
				while (!holding)
					@(posedge clk);
				no_idle = 1'b1;
				repeat (12) send_tick(1'b0, 1'b0);
				no_idle = 1'b0;
			end

			phase_start = sent_items;
			while (sent_items - phase_start < PhaseItems && sent_items < ItemTarget) begin
				pick = $urandom_range(0, 99);
				if (pick < 55) begin
					for (a = AxisX; a <= AxisE; a++)
						if ($urandom_range(0, 3) != 0)
							send_cmd(tspg_pkg::CmdW'(int'(tspg_pkg::CmdMoveX) + a),
								rand_bit(), rand_duration(), rand_steps());
					if ($urandom_range(0, 9) == 0)
						send_cmd(tspg_pkg::CmdAlive, rand_bit(), rand_duration(),
							rand_steps());
					send_cmd(tspg_pkg::CmdStart, rand_bit(), rand_duration(), rand_steps());
					repeat ($urandom_range(4, 60))
						send_tick(rare_limit(), rare_limit());
				end else if (pick < 80) begin
					send_cmd(tspg_pkg::CmdHome, rand_bit(), rand_duration(), rand_steps());
					if ($urandom_range(0, 2) == 0) begin
						send_cmd(tspg_pkg::CmdW'(int'(tspg_pkg::CmdMoveX)
							+ $urandom_range(0, 2)), rand_bit(), rand_duration(),
							rand_steps());
						send_cmd(tspg_pkg::CmdStart, 1'b0, '0, '0);
					end
					repeat ($urandom_range(2, 30))
						send_tick(rare_limit(), rare_limit());
					if ($urandom_range(0, 1) == 0)
						send_tick(1'b1, 1'b1);
				end else begin
					offer_item('{kind: rand_bit(), command: tspg_pkg::CmdW'($urandom),
						direction: rand_bit(), duration: tspg_pkg::DurW'($urandom),
						steps: tspg_pkg::StepInW'($urandom), x_limit: rand_bit(),
						z_limit: rand_bit()});
				end
			end
			await_quiet();
			no_idle = 1'b0;
			phase++;
		end

		$display("run covered %0d items over %0d home period settings, %0d results checked",
			sent_items, phase, tracker.checked);
		$display("homing ended %0d times, armed moves completed %0d times",
			tracker.home_events, tracker.move_events);
		if (tracker.fails == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
